@@ design/ped_pkg.sv @@
// Shared types and constants for the postfix expression evaluator.
`timescale 1ns / 1ps

package ped_pkg;

  // Operand width of a stack entry
  localparam int DATA_W = 8;

  // Character codes that carry meaning
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;
  localparam logic [7:0] CHR_PLUS  = 8'h2B;
  localparam logic [7:0] CHR_MINUS = 8'h2D;
  localparam logic [7:0] CHR_STAR  = 8'h2A;
  localparam logic [7:0] CHR_SLASH = 8'h2F;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic underflow;
    logic divide_by_zero;
    logic stack_full;
  } flags_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
  } div_status_t;

  // Map an operator character to its operation
  function automatic op_t decode_op(input logic [7:0] ch);
    op_t op;
    case (ch)
      CHR_PLUS:  op = OP_ADD;
      CHR_MINUS: op = OP_SUB;
      CHR_STAR:  op = OP_MUL;
      default:   op = OP_DIV;
    endcase
    return op;
  endfunction

endpackage

@@ design/ped_in_if.sv @@
// Character channel: valid/ready handshake with one expression character.
`timescale 1ns / 1ps

interface ped_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       end_of_expression;

  modport source (output valid, output character, output end_of_expression, input ready);
  modport sink   (input valid, input character, input end_of_expression, output ready);
endinterface

@@ design/ped_out_if.sv @@
// Result channel: valid/ready handshake with the value and error flags.
`timescale 1ns / 1ps

interface ped_out_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] value;
  logic              underflow;
  logic              divide_by_zero;
  logic              stack_full;

  modport source (output valid, output value, output underflow, output divide_by_zero,
                  output stack_full, input ready);
  modport sink   (input valid, input value, input underflow, input divide_by_zero,
                  input stack_full, output ready);
endinterface

@@ design/ped_stack_mem.sv @@
// Operand stack storage: one write port, one registered read port.
`timescale 1ns / 1ps

module ped_stack_mem
  import ped_pkg::*;
#(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write the pushed entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Register the read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ design/ped_div.sv @@
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps

module ped_div
  import ped_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output div_status_t       status
);

  localparam int CNT_W = $clog2(DATA_W);

  logic              busy;
  logic              done;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] dvs;
  logic              neg;

  logic [DATA_W:0]   shifted;
  logic              fits;
  logic [DATA_W-1:0] rem_next;
  logic [DATA_W-1:0] quo_next;
  logic [DATA_W-1:0] dividend_mag;
  logic [DATA_W-1:0] divisor_mag;

  // Take magnitudes of the operands
  assign dividend_mag = dividend[DATA_W-1] ? DATA_W'(-dividend) : dividend;
  assign divisor_mag  = divisor[DATA_W-1]  ? DATA_W'(-divisor)  : divisor;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign shifted  = {rem, quo[DATA_W-1]};
  assign fits     = shifted >= {1'b0, dvs};
  assign rem_next = fits ? DATA_W'(shifted - {1'b0, dvs}) : shifted[DATA_W-1:0];
  assign quo_next = {quo[DATA_W-2:0], fits};

  // Sequence the steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(DATA_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Advance the datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend_mag;
      dvs <= divisor_mag;
      neg <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  // Apply the sign; the magnitude 128 wraps back to -128
  assign status.done     = done;
  assign status.quotient = neg ? DATA_W'(-quo) : quo;

endmodule

@@ design/postfix_expression_evaluator_core.sv @@
// Top level of the postfix expression evaluator: control, arithmetic and result register.
`timescale 1ns / 1ps

// Evaluates a postfix expression fed one ASCII character per transaction. Digits push
// their value, + - * / pop two operands and push the 8-bit wrapped result, other
// characters are ignored. The top of the stack sits in a register, the rest in a
// one-port-write, one-port-read memory with registered read data. A digit or an ignored
// character needs only the idle state; + - * add the execute state, which waits on the
// stack memory read of the left operand; / also runs the 8-step bit-serial divider in
// the divide state (a zero divisor ends in the execute state). The ending character adds
// the finish state, which loads the result register once the previous result is taken.
// A new character is accepted while a finished result waits. No clearing pass is needed.
module postfix_expression_evaluator_core
  import ped_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input logic           clk,
  input logic           rst,
  ped_in_if.sink        chars,
  ped_out_if.source     results
);

  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1;

  state_t            state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [DATA_W-1:0] top, top_next;
  flags_t            flags, flags_next;
  op_t               op, op_next;
  logic [DATA_W-1:0] right_op, right_op_next;
  logic              left_mem, left_mem_next;
  logic              last, last_next;
  logic              out_valid, out_valid_next;
  logic [DATA_W-1:0] out_value, out_value_next;
  flags_t            out_flags, out_flags_next;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  logic              div_start;
  div_status_t       div_stat;

  logic              out_free;
  logic [DATA_W-1:0] left_op;
  logic [DATA_W-1:0] sum;
  logic [DATA_W-1:0] diff;
  logic [2*DATA_W-1:0] prod;

  ped_stack_mem #(
    .DEPTH  (STACK_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (top),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ped_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (left_op),
    .divisor  (right_op),
    .status   (div_stat)
  );

  // Spill the old top below the new one; read the left operand under the top
  assign mem_waddr = ADDR_W'(count - CNT_W'(1));
  assign mem_raddr = ADDR_W'(count - CNT_W'(2));

  // Arithmetic on the popped operands
  assign left_op = left_mem ? mem_rdata : '0;
  assign sum     = left_op + right_op;
  assign diff    = left_op - right_op;
  assign prod    = left_op * right_op;

  assign out_free = !out_valid || results.ready;

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      flags     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      flags     <= flags_next;
      out_valid <= out_valid_next;
    end
  end

  // Hold the payload
  always_ff @(posedge clk) begin
    top       <= top_next;
    op        <= op_next;
    right_op  <= right_op_next;
    left_mem  <= left_mem_next;
    last      <= last_next;
    out_value <= out_value_next;
    out_flags <= out_flags_next;
  end

  // Next state and datapath control
  always_comb begin
    state_next     = state;
    count_next     = count;
    top_next       = top;
    flags_next     = flags;
    op_next        = op;
    right_op_next  = right_op;
    left_mem_next  = left_mem;
    last_next      = last;
    out_value_next = out_value;
    out_flags_next = out_flags;
    out_valid_next = out_valid;
    mem_we         = 1'b0;
    div_start      = 1'b0;

    // Drop the result once taken
    if (results.valid && results.ready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      ST_IDLE: begin
        if (chars.valid) begin
          last_next = chars.end_of_expression;
          if (chars.character inside {[CHR_ZERO:CHR_NINE]}) begin
            // Push a digit, spilling the old top into memory
            if (count < CNT_W'(STACK_DEPTH)) begin
              mem_we     = (count != '0);
              top_next   = {{(DATA_W-4){1'b0}}, chars.character[3:0]};
              count_next = count + CNT_W'(1);
            end else begin
              flags_next.stack_full = 1'b1;
            end
            state_next = chars.end_of_expression ? ST_FIN : ST_IDLE;
          end else if (chars.character inside {CHR_PLUS, CHR_MINUS, CHR_STAR, CHR_SLASH}) begin
            // Pop both operands; the left one arrives from memory next cycle
            op_next       = decode_op(chars.character);
            right_op_next = (count != '0) ? top : '0;
            left_mem_next = (count >= CNT_W'(2));
            if (count >= CNT_W'(2)) begin
              count_next = count - CNT_W'(2);
            end else begin
              count_next           = '0;
              flags_next.underflow = 1'b1;
            end
            state_next = ST_EXEC;
          end else begin
            state_next = chars.end_of_expression ? ST_FIN : ST_IDLE;
          end
        end
      end

      ST_EXEC: begin
        // Push the result into the top register; a nonzero divisor starts the divider instead
        case (op)
          OP_ADD: begin
            top_next   = sum;
            count_next = count + CNT_W'(1);
            state_next = last ? ST_FIN : ST_IDLE;
          end
          OP_SUB: begin
            top_next   = diff;
            count_next = count + CNT_W'(1);
            state_next = last ? ST_FIN : ST_IDLE;
          end
          OP_MUL: begin
            top_next   = prod[DATA_W-1:0];
            count_next = count + CNT_W'(1);
            state_next = last ? ST_FIN : ST_IDLE;
          end
          default: begin
            if (right_op == '0) begin
              flags_next.divide_by_zero = 1'b1;
              top_next   = '0;
              count_next = count + CNT_W'(1);
              state_next = last ? ST_FIN : ST_IDLE;
            end else begin
              div_start  = 1'b1;
              state_next = ST_DIV;
            end
          end
        endcase
      end

      ST_DIV: begin
        if (div_stat.done) begin
          top_next   = div_stat.quotient;
          count_next = count + CNT_W'(1);
          state_next = last ? ST_FIN : ST_IDLE;
        end
      end

      ST_FIN: begin
        // Report the top and flags, then clear the stack for the next expression
        if (out_free) begin
          out_valid_next = 1'b1;
          out_value_next = (count != '0) ? top : '0;
          out_flags_next = flags;
          flags_next     = '0;
          count_next     = '0;
          state_next     = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign chars.ready            = (state == ST_IDLE);
  assign results.valid          = out_valid;
  assign results.value          = out_value;
  assign results.underflow      = out_flags.underflow;
  assign results.divide_by_zero = out_flags.divide_by_zero;
  assign results.stack_full     = out_flags.stack_full;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_FIN)
    else $error("result loaded outside the finish step");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == ST_DIV)
    else $error("divider finished while not awaited");

  a_fin_clears: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && out_free) |=> (count == '0 && flags == '0 && out_valid))
    else $error("stack not cleared after reporting");
`endif

endmodule

@@ test/postfix_expression_evaluator_core_tb.sv @@
// Self-checking testbench for the postfix expression evaluator core.
`timescale 1ns / 1ps

module postfix_expression_evaluator_core_tb
  import ped_pkg::*;
();

  localparam int DEPTH        = 16;
  localparam int MAX_CYCLES   = 300000;
  localparam int RANDOM_ITEMS = 700;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int N_DIRECTED   = 26;
  localparam int IDLE_PCT     = 27;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic signed [7:0] value;
    logic              underflow;
    logic              divide_by_zero;
    logic              stack_full;
  } result_t;

  // One directed row: a character repeated rep times, the last one may end the expression
  typedef struct packed {
    logic [7:0] ch;
    logic [4:0] rep;
    logic       last;
    logic       typed;
    result_t    res;
  } step_t;

  localparam result_t NO_RESULT = '0;

  localparam step_t DIRECTED_STEPS [N_DIRECTED] = '{
    // single digit straight out of reset
    '{CHR_ZERO + 8'd5, 5'd1, 1'b1, 1'b1, '{8'sd5, 1'b0, 1'b0, 1'b0}},
    // only an ignored character: empty stack reads zero
    '{8'h00, 5'd1, 1'b1, 1'b1, '{8'sd0, 1'b0, 1'b0, 1'b0}},
    // operator on an empty stack
    '{CHR_PLUS, 5'd1, 1'b1, 1'b1, '{8'sd0, 1'b1, 1'b0, 1'b0}},
    // 9 9 * with the top character code ignored in between
    '{CHR_NINE, 5'd1, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 5'd1, 1'b0, 1'b0, NO_RESULT},
    '{CHR_NINE, 5'd1, 1'b0, 1'b0, NO_RESULT},
    '{CHR_STAR, 5'd1, 1'b1, 1'b0, NO_RESULT},
    // 3 0 / divides by zero
    '{CHR_ZERO + 8'd3, 5'd1, 1'b0, 1'b0, NO_RESULT},
    '{CHR_ZERO, 5'd1, 1'b0, 1'b0, NO_RESULT},
    '{CHR_SLASH, 5'd1, 1'b1, 1'b1, '{8'sd0, 1'b0, 1'b1, 1'b0}},
    // 0 4 4 * - 8 * 0 1 - / : most negative value over minus one wraps to itself
    '{CHR_ZERO, 5'd1, 1'b0, 1'b0, NO_RESULT},
    '{CHR_ZERO + 8'd4, 5'd2, 1'b0, 1'b0, NO_RESULT},
    '{CHR_STAR, 5'd1, 1'b0, 1'b0, NO_RESULT},
    '{CHR_MINUS, 5'd1, 1'b0, 1'b0, NO_RESULT},
    '{CHR_ZERO + 8'd8, 5'd1, 1'b0, 1'b0, NO_RESULT},
    '{CHR_STAR, 5'd1, 1'b0, 1'b0, NO_RESULT},
    '{CHR_ZERO, 5'd1, 1'b0, 1'b0, NO_RESULT},
    '{CHR_ZERO + 8'd1, 5'd1, 1'b0, 1'b0, NO_RESULT},
    '{CHR_MINUS, 5'd1, 1'b0, 1'b0, NO_RESULT},
    '{CHR_SLASH, 5'd1, 1'b1, 1'b1, '{8'sh80, 1'b0, 1'b0, 1'b0}},
    // one push more than the stack holds is dropped
    '{CHR_ZERO + 8'd7, 5'd17, 1'b1, 1'b1, '{8'sd7, 1'b0, 1'b0, 1'b1}},
    // 0 7 - 2 / : division of a negative value truncates toward zero
    '{CHR_ZERO, 5'd1, 1'b0, 1'b0, NO_RESULT},
    '{CHR_ZERO + 8'd7, 5'd1, 1'b0, 1'b0, NO_RESULT},
    '{CHR_MINUS, 5'd1, 1'b0, 1'b0, NO_RESULT},
    '{CHR_ZERO + 8'd2, 5'd1, 1'b0, 1'b0, NO_RESULT},
    '{CHR_SLASH, 5'd1, 1'b1, 1'b0, NO_RESULT}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  ped_in_if  chars_bus ();
  ped_out_if results_bus ();

  postfix_expression_evaluator_core #(
    .STACK_DEPTH(DEPTH)
  ) uut (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars_bus),
    .results(results_bus)
  );

  // Mirror of the operand stack and sticky flags
  logic [7:0] mirror_stack [DEPTH];
  int         mirror_depth = 0;
  flags_t     mirror_flags = '0;

  result_t    expected_results [$];
  result_t    oldest_result;
  logic [7:0] expr_chars [$];

  int   failures = 0;
  int   cycle_count = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;
  logic hold_request = 1'b0;
  logic quiet = 1'b0;

  always #5 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  function automatic bit is_operator(input logic [7:0] ch);
    return ch == CHR_PLUS || ch == CHR_MINUS || ch == CHR_STAR || ch == CHR_SLASH;
  endfunction

  function automatic void push_operand(input logic [7:0] v);
    if (mirror_depth >= DEPTH) begin
      mirror_flags.stack_full = 1'b1;
    end else begin
      mirror_stack[mirror_depth] = v;
      mirror_depth++;
    end
  endfunction

  function automatic int pop_operand();
    if (mirror_depth == 0) begin
      mirror_flags.underflow = 1'b1;
      return 0;
    end
    mirror_depth--;
    return $signed(mirror_stack[mirror_depth]);
  endfunction

  // Apply one character to the mirror; return 1 with the report when it ends an expression
  function automatic bit evaluate_char(input logic [7:0] ch, input logic last,
                                       output result_t res);
    int lhs;
    int rhs;
    int r;
    res = '0;
    if (ch >= CHR_ZERO && ch <= CHR_NINE) begin
      push_operand(ch - CHR_ZERO);
    end else if (is_operator(ch)) begin
      rhs = pop_operand();
      lhs = pop_operand();
      case (ch)
        CHR_PLUS:  r = lhs + rhs;
        CHR_MINUS: r = lhs - rhs;
        CHR_STAR:  r = lhs * rhs;
        default: begin
          if (rhs == 0) begin
            mirror_flags.divide_by_zero = 1'b1;
            r = 0;
          end else begin
            r = lhs / rhs;
          end
        end
      endcase
      push_operand(r[7:0]);
    end
    if (!last) return 1'b0;
    res.value          = (mirror_depth == 0) ? 8'sd0 : mirror_stack[mirror_depth - 1];
    res.underflow      = mirror_flags.underflow;
    res.divide_by_zero = mirror_flags.divide_by_zero;
    res.stack_full     = mirror_flags.stack_full;
    // clear for the next expression
    mirror_depth = 0;
    mirror_flags = '0;
    return 1'b1;
  endfunction

  function automatic bit take_break();
    return !quiet && ($urandom_range(0, 99) < IDLE_PCT);
  endfunction

  function automatic logic [7:0] pick_operator();
    case ($urandom_range(0, 3))
      0:       return CHR_PLUS;
      1:       return CHR_MINUS;
      2:       return CHR_STAR;
      default: return CHR_SLASH;
    endcase
  endfunction

  function automatic logic [7:0] pick_digit();
    logic [7:0] d;
    d = $urandom_range(0, 9);
    return CHR_ZERO + d;
  endfunction

  // Fill expr_chars: mostly well-formed postfix, some broken sequences, some raw noise
  function automatic void build_expression();
    int         kind;
    int         operands;
    int         depth;
    int         len;
    logic [7:0] filler;
    expr_chars.delete();
    kind = $urandom_range(0, 9);
    if (kind < 7) begin
      operands = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 6);
      depth = 0;
      while (operands > 0 || depth > 1) begin
        if (operands > 0 && (depth < 2 || $urandom_range(0, 1) == 0)) begin
          expr_chars.push_back(pick_digit());
          operands--;
          depth++;
        end else begin
          expr_chars.push_back(pick_operator());
          depth--;
        end
        // sprinkle characters above the digit range, which are ignored
        if ($urandom_range(0, 9) == 0) begin
          filler = $urandom_range(8'h3A, 8'hFF);
          expr_chars.push_back(filler);
        end
      end
    end else if (kind < 9) begin
      len = $urandom_range(1, 8);
      repeat (len) expr_chars.push_back($urandom_range(0, 1) ? pick_operator() : pick_digit());
    end else begin
      len = $urandom_range(1, 6);
      repeat (len) begin
        filler = $urandom_range(0, 255);
        expr_chars.push_back(filler);
      end
    end
  endfunction

  // Offer one character, wait for the transaction, then record what it should produce
  task automatic send_char(input logic [7:0] ch, input logic last, input logic typed,
                           input result_t typed_res);
    result_t res;
    while (take_break()) begin
      chars_bus.valid <= 1'b0;
      @(posedge clk);
    end
    chars_bus.valid             <= 1'b1;
    chars_bus.character         <= ch;
    chars_bus.end_of_expression <= last;
    @(posedge clk);
    while (!chars_bus.ready) @(posedge clk);
    if (evaluate_char(ch, last, res)) expected_results.push_back(typed ? typed_res : res);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      failures++;
      if (failures <= MAX_REPORTS)
        $display("mismatch on %s at cycle %0d: expected %0d, got %0d",
                 name, cycle_count, want, got);
    end
  endtask

  // Hold off the result side for a long stretch once requested
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_request && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Compare each result transaction with the oldest expectation, then drive ready
  always @(posedge clk) begin
    if (!rst && results_bus.valid && results_bus.ready) begin
      if (expected_results.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("unexpected result at cycle %0d: value %0d", cycle_count,
                   results_bus.value);
      end else begin
        oldest_result = expected_results.pop_front();
        check_field("value", oldest_result.value, results_bus.value);
        check_field("underflow", oldest_result.underflow, results_bus.underflow);
        check_field("divide_by_zero", oldest_result.divide_by_zero,
                    results_bus.divide_by_zero);
        check_field("stack_full", oldest_result.stack_full, results_bus.stack_full);
      end
    end
    if (rst) begin
      results_bus.ready <= 1'b0;
    end else begin
      results_bus.ready <= (hold_left == 0) && (quiet || $urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Stimulus: directed table, then random expressions
  initial begin
    step_t row;
    int    n_items;
    int    n_expr;
    chars_bus.valid             = 1'b0;
    chars_bus.character         = 8'h00;
    chars_bus.end_of_expression = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++) begin
      row = DIRECTED_STEPS[i];
      for (int r = 1; r <= row.rep; r++)
        send_char(row.ch, row.last && r == row.rep, row.typed && r == row.rep, row.res);
    end

    n_items = 0;
    n_expr  = 0;
    while (n_items < RANDOM_ITEMS) begin
      if (n_expr == 20) hold_request <= 1'b1;
      if (n_expr == 45) quiet <= 1'b1;
      if (n_expr == 75) quiet <= 1'b0;
      build_expression();
      for (int k = 0; k < expr_chars.size(); k++) begin
        send_char(expr_chars[k], k == expr_chars.size() - 1, 1'b0, NO_RESULT);
        n_items++;
      end
      n_expr++;
    end
    chars_bus.valid <= 1'b0;

    // drain outstanding results, then watch for strays
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    wait (cycle_count >= MAX_CYCLES);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
